/* design/aabb_pkg.sv */
`default_nettype none
package aabb_pkg;

  localparam int DEF_MAX_ENTITIES    = 32;
  localparam int DEF_COORD_FRAC_BITS = 4;

  localparam int OWNER_W = 16;
  localparam int COORD_W = 16;
  localparam int MASK_W  = 32;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef logic [1:0] side_t;
  localparam side_t SIDE_LEFT   = 2'd0;
  localparam side_t SIDE_RIGHT  = 2'd1;
  localparam side_t SIDE_TOP    = 2'd2;
  localparam side_t SIDE_BOTTOM = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [OWNER_W-1:0]        owner;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] vel_x;
    logic signed [COORD_W-1:0] vel_y;
    logic [MASK_W-1:0]         group;
  } entity_t;

  typedef struct packed {
    logic load;
    logic wr_en;
    logic rd_en;
    logic capped;
    logic flush_push;
  } dp_cmd_t;

  typedef struct packed {
    logic advance;
    logic hit_take;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* design/aabb_if.sv */
`default_nettype none
interface aabb_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] owner;
  logic signed [15:0] min_x;
  logic signed [15:0] min_y;
  logic signed [15:0] max_x;
  logic signed [15:0] max_y;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic [31:0] group_mask;
  logic [31:0] filter_mask;

  modport source (
    output valid, mode, owner, min_x, min_y, max_x, max_y, vel_x, vel_y,
           group_mask, filter_mask,
    input  ready
  );
  modport sink (
    input  valid, mode, owner, min_x, min_y, max_x, max_y, vel_x, vel_y,
           group_mask, filter_mask,
    output ready
  );
endinterface

interface aabb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_owner;
  logic [15:0] second_owner;
  logic [1:0]  side;
  logic        last;

  modport source (
    output valid, first_owner, second_owner, side, last,
    input  ready
  );
  modport sink (
    input  valid, first_owner, second_owner, side, last,
    output ready
  );
endinterface
`default_nettype wire

/* design/aabb_pair_collision_finder.sv */
// aabb_pair_collision_finder: box-overlap collision search for one frame
//
// in_ch carries one item per handshake: mode 0 adds an entity, which is
// tested against every stored entity (stored one first, new one second)
// and then stored if the table has room; mode 1 empties the table.
// out_ch carries one item per hit, in store order of the first entity;
// last marks the final hit of an add item. An add with no hit gives none.
//
// an add item walks the stored entities (up to MAX_ENTITIES) through the
// single read port of the entity memory, one entry per cycle unless a
// stalled out_ch holds the walk. in_ch.ready is high only between items.
// the newest hit is held back one step so last can be set; a stalled
// out_ch holds the walk when a new hit finds both the output and the held hit full,
// and no hit is ever dropped except past the MAX_ENTITIES - 1 cap.
// reset empties the table; stored contents are not cleared, only the
// fill count, so no clearing pass is needed.
`default_nettype none
module aabb_pair_collision_finder import aabb_pkg::*; #(
  parameter int MAX_ENTITIES    = DEF_MAX_ENTITIES,
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  aabb_in_if.sink    in_ch,
  aabb_out_if.source out_ch
);

  localparam int IDX_W = $clog2(MAX_ENTITIES);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  entity_t          in_ent;

  // pack the incoming entity as it is stored
  assign in_ent.owner = in_ch.owner;
  assign in_ent.min_x = in_ch.min_x;
  assign in_ent.min_y = in_ch.min_y;
  assign in_ent.max_x = in_ch.max_x;
  assign in_ent.max_y = in_ch.max_y;
  assign in_ent.vel_x = in_ch.vel_x;
  assign in_ent.vel_y = in_ch.vel_y;
  assign in_ent.group = in_ch.group_mask;

  // sequencer: fill count, walk index, hit cap
  aabb_ctrl #(
    .MAX_ENTITIES(MAX_ENTITIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr)
  );

  // entity memory, pair test, held hit and output register
  aabb_dpath #(
    .MAX_ENTITIES    (MAX_ENTITIES),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .wr_addr          (wr_addr),
    .rd_addr          (rd_addr),
    .in_ent           (in_ent),
    .in_filter        (in_ch.filter_mask),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_first_owner  (out_ch.first_owner),
    .out_second_owner (out_ch.second_owner),
    .out_side         (out_ch.side),
    .out_last         (out_ch.last)
  );

endmodule
`default_nettype wire

/* design/aabb_ctrl.sv */
`default_nettype none
module aabb_ctrl import aabb_pkg::*; #(
  parameter int MAX_ENTITIES = DEF_MAX_ENTITIES,
  localparam int IDX_W = $clog2(MAX_ENTITIES),
  localparam int CNT_W = $clog2(MAX_ENTITIES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_mode,
  output logic                  in_ready,
  input  wire dp_stat_t         stat,
  output dp_cmd_t               cmd,
  output logic [IDX_W-1:0]      wr_addr,
  output logic [IDX_W-1:0]      rd_addr
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTITIES);
  localparam logic [IDX_W-1:0] HIT_CAP = IDX_W'(MAX_ENTITIES - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] walk_len_r, walk_len_nxt;
  logic [IDX_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic             accept;

  assign accept = (state_r == ST_IDLE) && in_valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_mode == MODE_ADD) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (idx_r == walk_len_r && stat.advance) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!stat.pend_valid || stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.wr_en      = 1'b0;
    cmd.rd_en      = 1'b0;
    cmd.flush_push = 1'b0;
    cmd.capped     = (hit_cnt_r == HIT_CAP);
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = accept && in_mode == MODE_ADD;
        cmd.wr_en = accept && in_mode == MODE_ADD && count_r < CNT_MAX;
      end
      ST_WALK: begin
        cmd.rd_en = (idx_r < walk_len_r) && stat.advance;
      end
      ST_FLUSH: begin
        cmd.flush_push = stat.pend_valid && stat.out_free;
      end
      default: ;
    endcase
  end

  assign wr_addr = count_r[IDX_W-1:0];
  assign rd_addr = idx_r[IDX_W-1:0];

  always_comb begin
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    walk_len_nxt = walk_len_r;
    hit_cnt_nxt  = hit_cnt_r;
    if (accept && in_mode == MODE_CLEAR) count_nxt = '0;
    if (cmd.wr_en) count_nxt = count_r + 1'b1;
    if (cmd.load) begin
      idx_nxt      = '0;
      walk_len_nxt = count_r;
      hit_cnt_nxt  = '0;
    end
    if (cmd.rd_en) idx_nxt = idx_r + 1'b1;
    if (stat.hit_take) hit_cnt_nxt = hit_cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      idx_r      <= '0;
      walk_len_r <= '0;
      hit_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      idx_r      <= idx_nxt;
      walk_len_r <= walk_len_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !stat.pend_valid)
    else $error("pending hit left over in idle");

  a_hit_cap: assert property (@(posedge clk) disable iff (!rst_n)
    stat.hit_take |-> hit_cnt_r < HIT_CAP)
    else $error("hit taken beyond cap");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> idx_r <= walk_len_r && walk_len_r <= CNT_MAX)
    else $error("walk index out of range");

endmodule
`default_nettype wire

/* design/aabb_dpath.sv */
`default_nettype none
module aabb_dpath import aabb_pkg::*; #(
  parameter int MAX_ENTITIES    = DEF_MAX_ENTITIES,
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
  localparam int IDX_W = $clog2(MAX_ENTITIES)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic [IDX_W-1:0]   wr_addr,
  input  wire logic [IDX_W-1:0]   rd_addr,
  input  wire entity_t            in_ent,
  input  wire logic [MASK_W-1:0]  in_filter,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [OWNER_W-1:0]      out_first_owner,
  output logic [OWNER_W-1:0]      out_second_owner,
  output side_t                   out_side,
  output logic                    out_last
);

  localparam logic signed [COORD_W:0] COORD_ONE = (COORD_W+1)'(1 << COORD_FRAC_BITS);
  localparam logic signed [COORD_W:0] NEG_ONE   = -COORD_ONE;

  entity_t            mem [MAX_ENTITIES];
  entity_t            rd_data_r;
  logic               b_valid_r;
  entity_t            cur_r;
  logic [MASK_W-1:0]  filter_r;

  logic               pend_valid_r;
  logic [OWNER_W-1:0] pend_first_r;
  side_t              pend_side_r;

  logic               out_valid_r;
  logic [OWNER_W-1:0] out_first_r, out_second_r;
  side_t              out_side_r;
  logic               out_last_r;

  entity_t e, s;
  logic    near_l, near_r, near_t, near_b;
  logic    overlap, vel_ok, hit_raw, out_free, advance, push_b;
  side_t   side;

  function automatic logic near_one(input logic signed [COORD_W-1:0] a,
                                    input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return (d < COORD_ONE) && (d > NEG_ONE);
  endfunction

  function automatic logic is_neg(input logic signed [COORD_W-1:0] v);
    return v[COORD_W-1];
  endfunction

  function automatic logic is_pos(input logic signed [COORD_W-1:0] v);
    return !v[COORD_W-1] && (v != '0);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= in_ent;
    if (cmd.rd_en) rd_data_r <= mem[rd_addr];
    if (cmd.load) begin
      cur_r    <= in_ent;
      filter_r <= in_filter;
    end
  end

  // stored entity is first, new entity is second
  assign e = rd_data_r;
  assign s = cur_r;

  always_comb begin
    near_l  = near_one(e.min_x, s.max_x);
    near_r  = near_one(e.max_x, s.min_x);
    near_t  = near_one(e.min_y, s.max_y);
    near_b  = near_one(e.max_y, s.min_y);
    overlap = !(e.min_x > s.max_x || e.min_y > s.max_y ||
                e.max_x < s.min_x || e.max_y < s.min_y);
    side    = SIDE_LEFT;
    vel_ok  = 1'b0;
    if (near_l) begin
      side   = SIDE_LEFT;
      vel_ok = is_neg(e.vel_x) || is_pos(s.vel_x);
    end else if (near_r) begin
      side   = SIDE_RIGHT;
      vel_ok = is_pos(e.vel_x) || is_neg(s.vel_x);
    end else if (near_t) begin
      side   = SIDE_TOP;
      vel_ok = is_neg(e.vel_y) || is_pos(s.vel_y);
    end else if (near_b) begin
      side   = SIDE_BOTTOM;
      vel_ok = is_pos(e.vel_y) || is_neg(s.vel_y);
    end
  end

  assign hit_raw  = b_valid_r && !cmd.capped && (e.owner != s.owner) &&
                    ((e.group & filter_r) != '0) && overlap && vel_ok;
  assign out_free = !out_valid_r || out_ready;
  assign advance  = !hit_raw || !pend_valid_r || out_free;
  assign push_b   = hit_raw && advance && pend_valid_r;

  assign stat.advance    = advance;
  assign stat.hit_take   = hit_raw && advance;
  assign stat.pend_valid = pend_valid_r;
  assign stat.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (advance) b_valid_r <= cmd.rd_en;
      if (stat.hit_take) pend_valid_r <= 1'b1;
      else if (cmd.flush_push) pend_valid_r <= 1'b0;
      if (push_b || cmd.flush_push) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.hit_take) begin
      pend_first_r <= e.owner;
      pend_side_r  <= side;
    end
    if (push_b || cmd.flush_push) begin
      out_first_r  <= pend_first_r;
      out_second_r <= cur_r.owner;
      out_side_r   <= pend_side_r;
      out_last_r   <= cmd.flush_push;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_first_owner  = out_first_r;
  assign out_second_owner = out_second_r;
  assign out_side         = out_side_r;
  assign out_last         = out_last_r;

  a_single_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_b && cmd.flush_push))
    else $error("walk and flush both load the output register");

  a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !pend_valid_r && !b_valid_r)
    else $error("new item loaded over work in flight");

  a_read_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> advance)
    else $error("read issued while the test stage is stalled");

endmodule
`default_nettype wire

/* sim/aabb_hit_checker.sv */
module aabb_hit_checker import aabb_pkg::*; #(
  parameter int MAX_ENTITIES    = DEF_MAX_ENTITIES,
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
  input  logic clk,
  input  logic rst_n,
  aabb_in_if   in_mon,
  aabb_out_if  out_mon,
  output int   mismatch_count,
  output int   hits_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 1 << COORD_FRAC_BITS;

  typedef struct packed {
    logic [OWNER_W-1:0] first_owner;
    logic [OWNER_W-1:0] second_owner;
    side_t              side;
    logic               last;
  } hit_t;

  entity_t roster [MAX_ENTITIES];
  int      roster_fill;
  hit_t    hit_q [$];
  int      errors;

  initial begin
    roster_fill    = 0;
    errors         = 0;
    mismatch_count = 0;
    hits_pending   = 0;
  end

  function automatic bit close_by(input int a, input int b);
    return (a - b < ONE) && (b - a < ONE);
  endfunction

  // side code for stored f against new s, -1 when the pair does not hit
  function automatic int contact_with(input entity_t f, input entity_t s);
    int fl, ft, fr, fb, sl, st, sr, sb;
    int fvx, fvy, svx, svy;
    fl = $signed(f.min_x);  ft = $signed(f.min_y);
    fr = $signed(f.max_x);  fb = $signed(f.max_y);
    sl = $signed(s.min_x);  st = $signed(s.min_y);
    sr = $signed(s.max_x);  sb = $signed(s.max_y);
    fvx = $signed(f.vel_x); fvy = $signed(f.vel_y);
    svx = $signed(s.vel_x); svy = $signed(s.vel_y);
    if (fl > sr || ft > sb || fr < sl || fb < st) return -1;
    // first side in range decides, velocity then only accepts or rejects
    if (close_by(fl, sr)) return (fvx < 0 || svx > 0) ? int'(SIDE_LEFT) : -1;
    if (close_by(fr, sl)) return (fvx > 0 || svx < 0) ? int'(SIDE_RIGHT) : -1;
    if (close_by(ft, sb)) return (fvy < 0 || svy > 0) ? int'(SIDE_TOP) : -1;
    if (close_by(fb, st)) return (fvy > 0 || svy < 0) ? int'(SIDE_BOTTOM) : -1;
    return -1;
  endfunction

  task automatic find_contacts();
    entity_t           fresh;
    logic [MASK_W-1:0] filter;
    hit_t              h;
    int                n, sd;
    fresh.owner = in_mon.owner;
    fresh.min_x = in_mon.min_x;
    fresh.min_y = in_mon.min_y;
    fresh.max_x = in_mon.max_x;
    fresh.max_y = in_mon.max_y;
    fresh.vel_x = in_mon.vel_x;
    fresh.vel_y = in_mon.vel_y;
    fresh.group = in_mon.group_mask;
    filter      = in_mon.filter_mask;
    n = 0;
    for (int i = 0; i < roster_fill; i++) begin
      if (roster[i].owner == fresh.owner) continue;
      if ((roster[i].group & filter) == '0) continue;
      sd = contact_with(roster[i], fresh);
      if (sd < 0) continue;
      if (n >= MAX_ENTITIES - 1) break;
      h.first_owner  = roster[i].owner;
      h.second_owner = fresh.owner;
      h.side         = side_t'(sd);
      h.last         = 1'b0;
      hit_q.push_back(h);
      n++;
    end
    if (n > 0) hit_q[hit_q.size() - 1].last = 1'b1;
    if (roster_fill < MAX_ENTITIES) begin
      roster[roster_fill] = fresh;
      roster_fill++;
    end
  endtask

  task automatic check_hit();
    hit_t got, want;
    got.first_owner  = out_mon.first_owner;
    got.second_owner = out_mon.second_owner;
    got.side         = out_mon.side;
    got.last         = out_mon.last;
    if (hit_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected hit first %h second %h side %0d last %0b, none expected",
               $time, got.first_owner, got.second_owner, got.side, got.last);
    end else begin
      want = hit_q.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: hit mismatch: expected first %h second %h side %0d last %0b, %s",
                 $time, want.first_owner, want.second_owner, want.side, want.last,
                 $sformatf("got first %h second %h side %0d last %0b",
                           got.first_owner, got.second_owner, got.side, got.last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      roster_fill = 0;
      hit_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.mode == MODE_CLEAR) roster_fill = 0;
        else find_contacts();
      end
      if (out_mon.valid && out_mon.ready) check_hit();
    end
    hits_pending   <= hit_q.size();
    mismatch_count <= errors;
  end

endmodule

/* sim/tb_aabb_pair_collision_finder.sv */
module tb_aabb_pair_collision_finder import aabb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 130;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // tail wait, long enough for an add to walk the whole table
  localparam int TAIL_CYCLES  = 2 * DEF_MAX_ENTITIES;
  // grid cell of 4.0 in Q12.4
  localparam int CELL         = 4 << DEF_COORD_FRAC_BITS;

  typedef struct {
    logic               mode;
    logic [15:0]        owner;
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [31:0]        group_mask;
    logic [31:0]        filter_mask;
  } entity_req_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  aabb_in_if  in_ch ();
  aabb_out_if out_ch ();

  aabb_pair_collision_finder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int mismatch_count;
  int hits_pending;

  // prediction and comparison live in the checker beside the block
  aabb_hit_checker hit_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .hits_pending   (hits_pending)
  );

  bit send_calm;   // sender runs back to back while set
  bit take_calm;   // receiver never stalls while set
  int items_sent;
  int cycle_count;

  // ---------------------------------------------------------------------------
  // item builders
  // ---------------------------------------------------------------------------

  function automatic entity_req_t add_item(input int owner, input int mnx, input int mny,
                                           input int mxx, input int mxy, input int vx,
                                           input int vy, input logic [31:0] grp,
                                           input logic [31:0] flt);
    entity_req_t r;
    r.mode        = MODE_ADD;
    r.owner       = 16'(owner);
    r.min_x       = 16'(mnx);
    r.min_y       = 16'(mny);
    r.max_x       = 16'(mxx);
    r.max_y       = 16'(mxy);
    r.vel_x       = 16'(vx);
    r.vel_y       = 16'(vy);
    r.group_mask  = grp;
    r.filter_mask = flt;
    return r;
  endfunction

  // clear carries junk in every other field, the block has to ignore it
  function automatic entity_req_t clear_item();
    entity_req_t r;
    r = add_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
    r.mode = MODE_CLEAR;
    return r;
  endfunction

  function automatic int jitter(input int reach);
    return int'($urandom_range(0, 2 * reach)) - reach;
  endfunction

  // zero, positive, negative or anything
  function automatic logic signed [15:0] rand_vel();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 16'($urandom_range(1, 32767));
      2:       return 16'(-int'($urandom_range(1, 32768)));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_mask(input bit may_be_zero);
    case ($urandom_range(0, 9))
      0:       return may_be_zero ? 32'h0 : 32'h1;
      1, 2:    return '1;
      3, 4:    return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input side: random gap, then hold valid until the handshake
  // ---------------------------------------------------------------------------

  task automatic push_item(input entity_req_t r);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= r.mode;
    in_ch.owner       <= r.owner;
    in_ch.min_x       <= r.min_x;
    in_ch.min_y       <= r.min_y;
    in_ch.max_x       <= r.max_x;
    in_ch.max_y       <= r.max_y;
    in_ch.vel_x       <= r.vel_x;
    in_ch.vel_y       <= r.vel_y;
    in_ch.group_mask  <= r.group_mask;
    in_ch.filter_mask <= r.filter_mask;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // hold off until every predicted hit has come out
  task automatic drain_hits();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (hits_pending != 0);
  endtask

  // ---------------------------------------------------------------------------
  // frame generators
  // ---------------------------------------------------------------------------

  // boxes on a 3x3 grid of cells around a random origin, so neighbors touch
  // within one unit most of the time; a few wild boxes and repeated owners
  task automatic grid_frame(input int adds);
    logic signed [15:0] ox, oy;
    logic [15:0]        owners [$];
    entity_req_t        r;
    int                 cx, cy;
    push_item(clear_item());
    ox = 16'($urandom);
    oy = 16'($urandom);
    repeat (adds) begin
      r.mode = MODE_ADD;
      if (owners.size() != 0 && $urandom_range(0, 5) == 0)
        r.owner = owners[$urandom_range(0, owners.size() - 1)];
      else
        r.owner = 16'($urandom);
      owners.push_back(r.owner);
      if ($urandom_range(0, 9) == 0) begin
        r.min_x = 16'($urandom);
        r.min_y = 16'($urandom);
        r.max_x = 16'($urandom);
        r.max_y = 16'($urandom);
      end else begin
        cx = $urandom_range(0, 2);
        cy = $urandom_range(0, 2);
        r.min_x = ox + 16'(cx * CELL + jitter(6));
        r.min_y = oy + 16'(cy * CELL + jitter(6));
        r.max_x = r.min_x + 16'(CELL + jitter(6));
        r.max_y = r.min_y + 16'(CELL + jitter(6));
      end
      r.vel_x       = rand_vel();
      r.vel_y       = rand_vel();
      r.group_mask  = rand_mask(1'b1);
      r.filter_mask = rand_mask(1'b1);
      push_item(r);
    end
  endtask

  // identical boxes (no contact among them) fill the table; probes past full
  // touch one side with velocity into the contact, so a probe with a full
  // filter hits every stored box and the hit cap is reached
  task automatic crowd_frame(input int adds);
    logic signed [15:0] bx, by;
    entity_req_t        r;
    int                 u;
    push_item(clear_item());
    bx = 16'(int'($urandom_range(0, 60000)) - 30000);
    by = 16'(int'($urandom_range(0, 60000)) - 30000);
    for (int k = 0; k < adds; k++) begin
      r.mode  = MODE_ADD;
      r.owner = 16'($urandom);
      r.min_x = bx;
      r.min_y = by;
      r.max_x = bx + 16'(CELL);
      r.max_y = by + 16'(CELL);
      r.vel_x = rand_vel();
      r.vel_y = rand_vel();
      u = $urandom_range(0, 15);
      if (k == adds - 1 || (k >= DEF_MAX_ENTITIES && $urandom_range(0, 2) == 0)) begin
        case ($urandom_range(0, 3))
          0: begin   // right of the crowd, moving left
            r.min_x = bx + 16'(CELL - u);
            r.max_x = r.min_x + 16'(CELL);
            r.vel_x = 16'(-int'($urandom_range(1, 32768)));
          end
          1: begin   // left of the crowd, moving right
            r.max_x = bx + 16'(u);
            r.min_x = r.max_x - 16'(CELL);
            r.vel_x = 16'($urandom_range(1, 32767));
          end
          2: begin   // above, moving down
            r.max_y = by + 16'(u);
            r.min_y = r.max_y - 16'(CELL);
            r.vel_y = 16'($urandom_range(1, 32767));
          end
          default: begin   // below, moving up
            r.min_y = by + 16'(CELL - u);
            r.max_y = r.min_y + 16'(CELL);
            r.vel_y = 16'(-int'($urandom_range(1, 32768)));
          end
        endcase
      end
      r.group_mask  = $urandom | 32'h1;
      r.filter_mask = ($urandom_range(0, 7) == 0) ? rand_mask(1'b0) : '1;
      push_item(r);
    end
  endtask

  // raw random items on top of whatever the table holds
  task automatic noise_burst(input int count);
    entity_req_t r;
    repeat (count) begin
      r = add_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
      if ($urandom_range(0, 5) == 0) r.mode = MODE_CLEAR;
      push_item(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall before each item, calm stretches in between
  // ---------------------------------------------------------------------------

  initial begin
    int stall;
    int taken;
    taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 40 == 0) take_calm = ($urandom_range(0, 3) == 0);
      stall = take_calm ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus and verdict
  // ---------------------------------------------------------------------------

  initial begin
    int start;
    int frame;
    int pick;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_ADD;
    in_ch.owner       <= '0;
    in_ch.min_x       <= '0;
    in_ch.min_y       <= '0;
    in_ch.max_x       <= '0;
    in_ch.max_y       <= '0;
    in_ch.vel_x       <= '0;
    in_ch.vel_y       <= '0;
    in_ch.group_mask  <= '0;
    in_ch.filter_mask <= '0;
    out_ch.ready      <= 1'b0;
    rst_n             <= 1'b0;
    send_calm  = 1'b0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: one contact per side around a box at the origin
    push_item(clear_item());
    push_item(add_item(1, 0, 0, CELL, CELL, 0, 0, 32'h1, '1));
    push_item(add_item(2, CELL, 0, 2 * CELL, CELL, -16, 0, 32'h1, '1));
    push_item(add_item(3, -CELL, 0, 0, CELL, 16, 0, 32'h2, '1));
    push_item(add_item(4, 0, -CELL, CELL, 0, 0, 16, 32'h4, '1));
    push_item(add_item(5, 0, CELL, CELL, 2 * CELL, 0, -16, 32'h8, '1));
    // same owner as a touching box is skipped
    push_item(add_item(1, CELL, 0, 2 * CELL, CELL, -16, 0, 32'h1, '1));
    // empty filter
    push_item(add_item(6, CELL, 0, 2 * CELL, CELL, -16, 0, '1, 32'h0));
    // touching but moving away
    push_item(add_item(7, CELL, 0, 2 * CELL, CELL, 16, 0, '1, 32'h1));
    // overlap with no side within one
    push_item(add_item(8, 16, 16, 48, 48, -16, -16, '1, '1));
    // inverted box, then the coordinate and velocity extremes
    push_item(add_item(9, CELL, CELL, 0, 0, 16, 16, '1, '1));
    push_item(add_item(16'hFFFF, -32768, -32768, 32767, 32767, -32768, 32767, '1, '1));
    push_item(add_item(0, 32767, 32767, -32768, -32768, 32767, -32768, 32'h0, '1));
    // contact distance just under and exactly at one unit
    push_item(clear_item());
    push_item(add_item(10, 0, 0, CELL, CELL, 16, 0, '1, '1));
    push_item(add_item(11, CELL - 15, 16, 200, 48, 0, 0, '1, '1));
    push_item(add_item(12, CELL - 16, 16, 200, 48, 0, 0, '1, '1));
    drain_hits();

    // random frames; the second one is always a crowd to fill the table
    start = items_sent;
    frame = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      send_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (frame == 1 || pick == 0) crowd_frame($urandom_range(33, 36));
      else if (pick < 3)           noise_burst($urandom_range(3, 8));
      else if (pick < 5)           grid_frame($urandom_range(20, 36));
      else                         grid_frame($urandom_range(1, 10));
      if ($urandom_range(0, 4) == 0) drain_hits();
      frame++;
    end

    // let the last hits come out, then allow for a stray late one
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (hits_pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/aabb_pkg.sv
design/aabb_if.sv
design/aabb_ctrl.sv
design/aabb_dpath.sv
design/aabb_pair_collision_finder.sv
sim/aabb_hit_checker.sv
sim/tb_aabb_pair_collision_finder.sv
